FILE: sv/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the chunked body decoder: character codes,
// status and error codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	// Character codes
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LINE  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ODD_CHECK = 2'd1;

	// Register reset values
	localparam logic [7:0] MAX_LINE_RESET  = 8'd100;
	localparam logic       ODD_CHECK_RESET = 1'b0;

	// Status codes
	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} hcbd_status_t;

	// Error kinds
	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_LINE_LONG = 3'd1,
		ERR_ODD_LINE  = 3'd2,
		ERR_BAD_TERM  = 3'd3,
		ERR_AFTER_END = 3'd4,
		ERR_OVERFLOW  = 3'd5
	} hcbd_err_t;

	// One result beat
	typedef struct packed {
		logic [7:0]   payload_byte;
		logic         payload_valid;
		logic         chunk_last;
		hcbd_status_t status;
		hcbd_err_t    error_kind;
	} hcbd_result_t;

	// Decode a hex character: bit 4 set when valid, bits 3:0 the digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

FILE: sv/hcbd_core.sv
// ----------------------------------------------------------------------------
// hcbd_core
// Per-byte decoder state machine. Holds the phase, size accumulator, data
// down counter, line counter and configuration registers, and works out the
// result of each accepted byte combinationally.
// ----------------------------------------------------------------------------
module hcbd_core #(
	parameter int unsigned SIZE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [hcbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [7:0]                          cfg_data,
	input  logic                                step,
	input  logic [7:0]                          in_byte,
	input  logic                                restart,
	output hcbd_pkg::hcbd_result_t              res
);
	import hcbd_pkg::*;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_DATA,
		PH_TERM_CR,
		PH_TERM_LF,
		PH_END_CR,
		PH_END_LF,
		PH_DONE,
		PH_ERROR
	} phase_t;

	phase_t               phase_q, cur_phase, nxt_phase;
	logic [SIZE_BITS-1:0] chunk_len_q, cur_len, nxt_len;
	logic [SIZE_BITS-1:0] bytes_left_q, cur_left, nxt_left;
	logic [7:0]           line_count_q, cur_count, nxt_count;
	logic                 pending_cr_q, cur_pend, nxt_pend;
	logic                 digits_ended_q, cur_dig, nxt_dig;
	hcbd_err_t            saved_err_q, cur_err, nxt_err;
	logic [7:0]           max_line_q;
	logic                 odd_check_q;
	logic [4:0]           hex;

	// Restart clears the state before this byte is looked at
	always_comb begin
		if (restart) begin
			cur_phase = PH_SIZE;
			cur_len   = '0;
			cur_left  = '0;
			cur_count = '0;
			cur_pend  = 1'b0;
			cur_dig   = 1'b0;
			cur_err   = ERR_NONE;
		end else begin
			cur_phase = phase_q;
			cur_len   = chunk_len_q;
			cur_left  = bytes_left_q;
			cur_count = line_count_q;
			cur_pend  = pending_cr_q;
			cur_dig   = digits_ended_q;
			cur_err   = saved_err_q;
		end
	end

	assign hex = hex_decode(in_byte);

	// Advance the state machine by one byte
	always_comb begin
		nxt_phase = cur_phase;
		nxt_len   = cur_len;
		nxt_left  = cur_left;
		nxt_count = cur_count;
		nxt_pend  = cur_pend;
		nxt_dig   = cur_dig;
		nxt_err   = cur_err;
		res       = '{payload_byte: 8'd0, payload_valid: 1'b0, chunk_last: 1'b0,
		              status: ST_BUSY, error_kind: ERR_NONE};
		case (cur_phase)
			PH_SIZE: begin
				if (cur_pend && in_byte == CH_LF) begin
					// count includes the CR, so an odd text length has an even count
					if (odd_check_q && !cur_count[0]) begin
						nxt_phase = PH_ERROR;
						nxt_err   = ERR_ODD_LINE;
					end else begin
						nxt_count = '0;
						nxt_pend  = 1'b0;
						nxt_dig   = 1'b0;
						if (cur_len == '0) begin
							nxt_phase = PH_END_CR;
						end else begin
							nxt_left  = cur_len;
							nxt_phase = PH_DATA;
						end
					end
				end else begin
					nxt_pend = 1'b0;
					if (cur_count >= max_line_q) begin
						nxt_phase = PH_ERROR;
						nxt_err   = ERR_LINE_LONG;
					end else begin
						nxt_count = cur_count + 8'd1;
						if (in_byte == CH_CR) begin
							nxt_pend = 1'b1;
							nxt_dig  = 1'b1;
						end else if (!cur_dig) begin
							if (!hex[4]) begin
								nxt_dig = 1'b1;
							end else if (cur_len[SIZE_BITS-1 -: 4] != 4'd0) begin
								nxt_phase = PH_ERROR;
								nxt_err   = ERR_OVERFLOW;
							end else begin
								nxt_len = {cur_len[SIZE_BITS-5:0], hex[3:0]};
							end
						end
					end
				end
			end
			PH_DATA: begin
				res.payload_byte  = in_byte;
				res.payload_valid = 1'b1;
				nxt_left = cur_left - SIZE_BITS'(1);
				if (cur_left == SIZE_BITS'(1)) begin
					res.chunk_last = 1'b1;
					nxt_phase      = PH_TERM_CR;
				end
			end
			PH_TERM_CR: begin
				if (in_byte == CH_CR) begin
					nxt_phase = PH_TERM_LF;
				end else begin
					nxt_phase = PH_ERROR;
					nxt_err   = ERR_BAD_TERM;
				end
			end
			PH_TERM_LF: begin
				if (in_byte == CH_LF) begin
					nxt_phase = PH_SIZE;
					nxt_len   = '0;
					nxt_count = '0;
					nxt_pend  = 1'b0;
					nxt_dig   = 1'b0;
				end else begin
					nxt_phase = PH_ERROR;
					nxt_err   = ERR_BAD_TERM;
				end
			end
			PH_END_CR: begin
				if (in_byte == CH_CR) begin
					nxt_phase = PH_END_LF;
				end else begin
					nxt_phase = PH_ERROR;
					nxt_err   = ERR_BAD_TERM;
				end
			end
			PH_END_LF: begin
				if (in_byte == CH_LF) begin
					nxt_phase  = PH_DONE;
					res.status = ST_DONE;
				end else begin
					nxt_phase = PH_ERROR;
					nxt_err   = ERR_BAD_TERM;
				end
			end
			PH_DONE: begin
				nxt_phase = PH_ERROR;
				nxt_err   = ERR_AFTER_END;
			end
			default: begin
			end
		endcase

		// Error answers override everything else
		if (nxt_phase == PH_ERROR) begin
			res = '{payload_byte: 8'd0, payload_valid: 1'b0, chunk_last: 1'b0,
			        status: ST_ERROR, error_kind: nxt_err};
		end
	end

	// Hold state and configuration; update on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SIZE;
			chunk_len_q    <= '0;
			bytes_left_q   <= '0;
			line_count_q   <= '0;
			pending_cr_q   <= 1'b0;
			digits_ended_q <= 1'b0;
			saved_err_q    <= ERR_NONE;
			max_line_q     <= MAX_LINE_RESET;
			odd_check_q    <= ODD_CHECK_RESET;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_MAX_LINE) begin
					max_line_q <= cfg_data;
				end else if (cfg_index == CFG_ODD_CHECK) begin
					odd_check_q <= cfg_data[0];
				end
			end
			if (step) begin
				phase_q        <= nxt_phase;
				chunk_len_q    <= nxt_len;
				bytes_left_q   <= nxt_left;
				line_count_q   <= nxt_count;
				pending_cr_q   <= nxt_pend;
				digits_ended_q <= nxt_dig;
				saved_err_q    <= nxt_err;
			end
		end
	end

endmodule

FILE: sv/hcbd_out_buf.sv
// ----------------------------------------------------------------------------
// hcbd_out_buf
// Result register with one skid entry, so the input side keeps taking beats
// while a finished result waits on the output side.
// ----------------------------------------------------------------------------
module hcbd_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  hcbd_pkg::hcbd_result_t push_data,
	output logic                   full,
	output logic                   out_valid,
	input  logic                   out_stall,
	output hcbd_pkg::hcbd_result_t out_data
);
	import hcbd_pkg::*;

	logic         main_valid_q, skid_valid_q;
	hcbd_result_t main_q, skid_q;
	logic         take;

	assign take      = main_valid_q && !out_stall;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign full      = skid_valid_q;

	// Control: drain the skid entry first, then fill main or skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (take) begin
			main_valid_q <= 1'b0;
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !take) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

FILE: sv/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked transfer coded body, one byte per beat.
// ----------------------------------------------------------------------------
// The decoder takes one body byte per clock while in_stall is low and
// returns exactly one registered result beat per input byte. The per-byte
// state machine and the hex shift-add size accumulator are combinational,
// so sustained throughput is one byte per cycle when not stalled; a result
// register plus one skid entry keep the input open while the output side
// stalls, and in_stall rises only when both are occupied. Errors are sticky
// until a byte arrives with restart set. Configuration writes take effect
// at once and are meant to be issued only while no byte is in flight.
module http_chunked_body_decoder #(
	parameter int unsigned SIZE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [hcbd_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [7:0]                        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        in_byte,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        payload_byte,
	output logic                              payload_valid,
	output logic                              chunk_last,
	output logic [1:0]                        status,
	output logic [2:0]                        error_kind
);
	import hcbd_pkg::*;

	logic         step;
	logic         buf_full;
	hcbd_result_t step_res;
	hcbd_result_t out_res;

	// Accept a byte whenever the output side has room
	assign in_stall = buf_full;
	assign step     = in_valid && !buf_full;

	hcbd_core #(
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.in_byte   (in_byte),
		.restart   (restart),
		.res       (step_res)
	);

	hcbd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_data (step_res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	// Unpack the result beat onto its ports
	assign payload_byte  = out_res.payload_byte;
	assign payload_valid = out_res.payload_valid;
	assign chunk_last    = out_res.chunk_last;
	assign status        = out_res.status;
	assign error_kind    = out_res.error_kind;

endmodule

FILE: dv/hcbd_checker.sv
// ----------------------------------------------------------------------------
// hcbd_checker
// Watches the configuration port and both byte channels of the chunked body
// decoder. Mirrors the register writes, predicts one result beat for every
// accepted body byte and compares each accepted result beat against the
// oldest prediction, field by field. Reports the failure count to the top.
// ----------------------------------------------------------------------------
module hcbd_checker #(
	parameter int unsigned SIZE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [hcbd_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [7:0]                        cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [7:0]                        in_byte,
	input  logic                              restart,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [7:0]                        payload_byte,
	input  logic                              payload_valid,
	input  logic                              chunk_last,
	input  logic [1:0]                        status,
	input  logic [2:0]                        error_kind,
	output int                                fail_count,
	output int                                outstanding,
	output int                                results_seen,
	output int                                done_seen,
	output logic [7:0]                        kinds_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import hcbd_pkg::*;

	typedef enum logic [2:0] {
		P_SIZE,
		P_DATA,
		P_TERM_CR,
		P_TERM_LF,
		P_END_CR,
		P_END_LF,
		P_DONE,
		P_ERROR
	} dec_phase_t;

	// Register mirror
	logic [7:0]           max_line = MAX_LINE_RESET;
	logic                 odd_chk  = ODD_CHECK_RESET;

	// Decoder state copy
	dec_phase_t           ph        = P_SIZE;
	logic [SIZE_BITS-1:0] chunk_len = '0;
	logic [SIZE_BITS-1:0] bytes_left = '0;
	logic [7:0]           line_cnt  = '0;
	logic                 pend_cr   = 1'b0;
	logic                 dig_end   = 1'b0;
	hcbd_err_t            saved_err = ERR_NONE;

	hcbd_result_t         predicted_beats[$];
	int                   errs = 0;

	initial begin
		fail_count   = 0;
		outstanding  = 0;
		results_seen = 0;
		done_seen    = 0;
		kinds_seen   = '0;
	end

	// Clear the line trackers to await a fresh size line
	function automatic void open_line();
		ph        = P_SIZE;
		chunk_len = '0;
		line_cnt  = '0;
		pend_cr   = 1'b0;
		dig_end   = 1'b0;
	endfunction

	// Enter the sticky error state
	function automatic void trap(input hcbd_err_t kind);
		ph        = P_ERROR;
		saved_err = kind;
	endfunction

	// Advance the decoder by one body byte and return the result beat it causes
	function automatic hcbd_result_t decode_step(input logic [7:0] b, input logic rs);
		hcbd_result_t r;
		logic [7:0]   chars;
		logic         is_hex;
		logic [3:0]   nib;
		r              = '0;
		r.status       = ST_BUSY;
		r.error_kind   = ERR_NONE;
		is_hex         = 1'b0;
		nib            = '0;
		if (rs) begin
			open_line();
			bytes_left = '0;
			saved_err  = ERR_NONE;
		end
		case (ph)
			P_SIZE: begin
				if (pend_cr && b == CH_LF) begin
					// CRLF closes the size line
					chars = line_cnt - 8'd1;
					if (odd_chk && chars[0]) begin
						trap(ERR_ODD_LINE);
					end else begin
						line_cnt = '0;
						pend_cr  = 1'b0;
						dig_end  = 1'b0;
						if (chunk_len == '0) begin
							ph = P_END_CR;
						end else begin
							bytes_left = chunk_len;
							ph         = P_DATA;
						end
					end
				end else begin
					pend_cr = 1'b0;
					if (line_cnt >= max_line) begin
						trap(ERR_LINE_LONG);
					end else begin
						line_cnt = line_cnt + 8'd1;
						if (b == CH_CR) begin
							// a CR may open the line end; it always ends the digits
							pend_cr = 1'b1;
							dig_end = 1'b1;
						end else if (!dig_end) begin
							if (b >= 8'h30 && b <= 8'h39) begin
								is_hex = 1'b1;
								nib    = 4'(b - 8'h30);
							end else if (b >= 8'h61 && b <= 8'h66) begin
								is_hex = 1'b1;
								nib    = 4'(b - 8'h57);
							end else if (b >= 8'h41 && b <= 8'h46) begin
								is_hex = 1'b1;
								nib    = 4'(b - 8'h37);
							end
							if (!is_hex) begin
								dig_end = 1'b1;
							end else if (chunk_len[SIZE_BITS-1 -: 4] != 4'd0) begin
								trap(ERR_OVERFLOW);
							end else begin
								chunk_len = {chunk_len[SIZE_BITS-5:0], nib};
							end
						end
					end
				end
			end
			P_DATA: begin
				r.payload_byte  = b;
				r.payload_valid = 1'b1;
				bytes_left      = bytes_left - SIZE_BITS'(1);
				if (bytes_left == '0) begin
					r.chunk_last = 1'b1;
					ph           = P_TERM_CR;
				end
			end
			P_TERM_CR: begin
				if (b == CH_CR) ph = P_TERM_LF;
				else trap(ERR_BAD_TERM);
			end
			P_TERM_LF: begin
				if (b == CH_LF) open_line();
				else trap(ERR_BAD_TERM);
			end
			P_END_CR: begin
				if (b == CH_CR) ph = P_END_LF;
				else trap(ERR_BAD_TERM);
			end
			P_END_LF: begin
				if (b == CH_LF) begin
					ph       = P_DONE;
					r.status = ST_DONE;
				end else begin
					trap(ERR_BAD_TERM);
				end
			end
			P_DONE: begin
				trap(ERR_AFTER_END);
			end
			default: begin
			end
		endcase
		// Errors mask the payload and report the saved kind
		if (ph == P_ERROR) begin
			r.payload_byte  = '0;
			r.payload_valid = 1'b0;
			r.chunk_last    = 1'b0;
			r.status        = ST_ERROR;
			r.error_kind    = saved_err;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Mirror writes, predict accepted bytes, compare accepted results
	always @(posedge clk or negedge arst_n) begin : watch
		hcbd_result_t want;
		if (!arst_n) begin
			max_line   = MAX_LINE_RESET;
			odd_chk    = ODD_CHECK_RESET;
			open_line();
			bytes_left = '0;
			saved_err  = ERR_NONE;
			predicted_beats.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_MAX_LINE:  max_line = cfg_data;
					CFG_ODD_CHECK: odd_chk  = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				if (predicted_beats.size() == 0) begin
					errs++;
					$display("%0t ns: unexpected result beat: byte %0h status %0h kind %0h",
						$time, payload_byte, status, error_kind);
				end else begin
					want = predicted_beats[0];
					predicted_beats.delete(0);
					results_seen++;
					check_field("payload_byte", want.payload_byte, payload_byte);
					check_field("payload_valid", 8'(want.payload_valid), 8'(payload_valid));
					check_field("chunk_last", 8'(want.chunk_last), 8'(chunk_last));
					check_field("status", 8'(want.status), 8'(status));
					check_field("error_kind", 8'(want.error_kind), 8'(error_kind));
				end
			end
			if (in_valid && !in_stall) begin
				want = decode_step(in_byte, restart);
				if (want.status == ST_DONE) done_seen++;
				if (want.status == ST_ERROR) kinds_seen[want.error_kind] = 1'b1;
				predicted_beats.push_back(want);
			end
			outstanding <= predicted_beats.size();
			fail_count  <= errs;
		end
	end

endmodule

FILE: dv/tb_http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// Drives chunked request bodies into the decoder: a short directed sequence
// over payload extremes, empty size lines, lone CRs, overflow, bad
// terminators and bytes past the end, then random messages under several
// register settings with random gaps and output stalls. A checker instance
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import hcbd_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;
	localparam int unsigned RANDOM_BYTES = 650;
	localparam int unsigned PHASE_BYTES  = 90;
	localparam int unsigned RUN_LIMIT_NS = 4_000_000;

	typedef struct packed {
		logic [7:0] data;
		logic       rs;
	} body_beat_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [7:0]              cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic [7:0]              in_byte   = '0;
	logic                    restart   = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [7:0]              payload_byte;
	logic                    payload_valid;
	logic                    chunk_last;
	logic [1:0]              status;
	logic [2:0]              error_kind;

	int                      fail_count;
	int                      outstanding;
	int                      results_seen;
	int                      done_seen;
	logic [7:0]              kinds_seen;

	body_beat_t              pending_beats[$];
	int unsigned             sent_items = 0;
	int unsigned             phases_run = 0;
	bit                      quiet      = 1'b0;
	logic [7:0]              cur_max    = MAX_LINE_RESET;
	logic                    cur_odd    = ODD_CHECK_RESET;

	always #2 clk = ~clk;

	http_chunked_body_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.chunk_last    (chunk_last),
		.status        (status),
		.error_kind    (error_kind)
	);

	hcbd_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.chunk_last    (chunk_last),
		.status        (status),
		.error_kind    (error_kind),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.results_seen  (results_seen),
		.done_seen     (done_seen),
		.kinds_seen    (kinds_seen)
	);

	// Wait length for one beat; quiet stretches run back to back
	function automatic int unsigned pick_gap();
		if (quiet) return 0;
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return $urandom_range(0, 2);
			default: return $urandom_range(0, 17);
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	task automatic push_beat(input logic [7:0] b, input logic rs);
		pending_beats.push_back('{data: b, rs: rs});
	endtask

	task automatic push_str(input string s, input logic rs_first);
		for (int i = 0; i < s.len(); i++) push_beat(s[i], rs_first && i == 0);
	endtask

	task automatic push_crlf();
		push_beat(CH_CR, 1'b0);
		push_beat(CH_LF, 1'b0);
	endtask

	// Chunk terminator, now and then corrupted
	task automatic push_term();
		push_crlf();
		if ($urandom_range(0, 29) == 0)
			pending_beats[pending_beats.size() - 1 - $urandom_range(0, 1)].data =
				8'($urandom_range(0, 255));
	endtask

	// Size line for a chunk; fit keeps it legal under the current registers
	task automatic push_size_line(input int unsigned size, input logic rs_first,
			input bit fit, output int unsigned eff);
		logic [7:0] line[$];
		logic [7:0] c;
		bit         has_ext;
		logic       first;
		eff = size;
		if (size == 0) begin
			if ($urandom_range(0, 1)) line.push_back(8'h30);
		end else begin
			for (int sh = 28; sh >= 0; sh -= 4)
				if ((size >> sh) != 0) line.push_back(hex_char(4'((size >> sh) & 15)));
		end
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) line.push_front(8'h30);
		has_ext = ($urandom_range(0, 2) == 0);
		if (has_ext) begin
			line.push_back(8'h3B);
			repeat ($urandom_range(0, 4)) begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_CR) c = 8'h78;
				line.push_back(c);
			end
		end
		if (fit) begin
			if (line.size() + 1 > cur_max) begin
				line.delete();
				eff     = 0;
				has_ext = 1'b0;
			end
			// pad or trim to an even character count
			if (cur_odd && (line.size() % 2) == 1) begin
				if (line.size() + 2 <= cur_max) line.push_front(8'h30);
				else if (has_ext) void'(line.pop_back());
				else begin
					line.delete();
					eff = 0;
				end
			end
		end
		first = rs_first;
		foreach (line[i]) begin
			push_beat(line[i], first);
			first = 1'b0;
		end
		push_beat(CH_CR, first);
		push_beat(CH_LF, 1'b0);
	endtask

	// Queue one message: mostly well formed, some overflow lines and noise
	task automatic push_message();
		int unsigned kind;
		int unsigned nch;
		int unsigned size;
		int unsigned eff;
		logic        first;
		bit          fit;
		logic [7:0]  c;
		kind = $urandom_range(0, 9);
		if (kind <= 7) begin
			fit   = ($urandom_range(0, 9) != 0);
			first = 1'b1;
			nch   = $urandom_range(0, 3);
			eff   = 1;
			for (int k = 0; k < nch && eff != 0; k++) begin
				size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
				push_size_line(size, first, fit, eff);
				first = 1'b0;
				if (eff != 0) begin
					repeat (eff) push_beat(8'($urandom_range(0, 255)), 1'b0);
					push_term();
				end
			end
			if (eff != 0) push_size_line(0, first, fit, eff);
			push_term();
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 2)) push_beat(8'($urandom_range(0, 255)), 1'b0);
		end else if (kind == 8) begin
			// more significant digits than the size holds
			push_beat(hex_char(4'($urandom_range(1, 15))), 1'b1);
			repeat ($urandom_range(8, 9)) push_beat(hex_char(4'($urandom_range(0, 15))), 1'b0);
			push_crlf();
		end else begin
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 3))
					0:       c = CH_CR;
					1:       c = CH_LF;
					2:       c = hex_char(4'($urandom_range(0, 15)));
					default: c = 8'($urandom_range(0, 255));
				endcase
				push_beat(c, $urandom_range(0, 5) == 0);
			end
		end
	endtask

	// Send every queued beat, one handshake each
	task automatic send_queued();
		body_beat_t  bb;
		int unsigned gap;
		while (pending_beats.size() != 0) begin
			bb  = pending_beats[0];
			pending_beats.delete(0);
			gap = pick_gap();
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte  <= bb.data;
			restart  <= bb.rs;
			@(posedge clk);
			while (in_stall) @(posedge clk);
			sent_items++;
		end
	endtask

	// Drop valid and hold until every predicted beat has come back
	task automatic wait_idle(input int unsigned tail);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic load_regs(input logic [7:0] max_val, input logic odd_val, input bit spare);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_MAX_LINE;
		cfg_data  <= max_val;
		@(posedge clk);
		cfg_index <= CFG_ODD_CHECK;
		cfg_data  <= {7'($urandom_range(0, 127)), odd_val};
		@(posedge clk);
		if (spare) begin
			cfg_index <= CFG_SPARE_2;
			cfg_data  <= 8'($urandom_range(0, 255));
			@(posedge clk);
			cfg_index <= CFG_SPARE_3;
			cfg_data  <= 8'($urandom_range(0, 255));
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		cur_max = max_val;
		cur_odd = odd_val;
	endtask

	// Receiver: stall a random number of cycles before each result beat
	initial begin
		int unsigned hold;
		@(posedge clk);
		forever begin
			hold = pick_gap();
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("tb_http_chunked_body_decoder: FAIL");
		$finish;
	end

	initial begin
		logic [7:0]  max_tab[6];
		logic        odd_tab[6];
		logic [7:0]  nmax;
		logic        nodd;
		int unsigned rand_start;
		int unsigned phase_start;
		max_tab = '{8'd255, 8'd1, 8'd4, 8'd17, 8'd2, 8'd100};
		odd_tab = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one byte chunk with an extension, empty size line, then past the end
		push_str("1;", 1'b0);
		push_crlf();
		push_beat(8'hFF, 1'b0);
		push_crlf();
		push_crlf();
		push_crlf();
		push_beat(8'h00, 1'b0);
		push_beat("A", 1'b0);
		// size overflow on the ninth digit
		push_str("fFFFFFFF0", 1'b1);
		// lone CR inside the size line, then a bad terminator
		push_str("1", 1'b1);
		push_beat(CH_CR, 1'b0);
		push_str("g", 1'b0);
		push_crlf();
		push_beat(8'h00, 1'b0);
		push_str("X", 1'b0);
		send_queued();

		// Zero line limit rejects the first size byte
		wait_idle(4);
		load_regs(8'd0, 1'b0, 1'b0);
		push_str("1", 1'b1);
		push_crlf();
		send_queued();

		// Random messages over several register settings
		rand_start = sent_items;
		while (sent_items - rand_start < RANDOM_BYTES) begin
			wait_idle(4);
			if (phases_run < 6) begin
				nmax = max_tab[phases_run];
				nodd = odd_tab[phases_run];
			end else begin
				nmax = 8'($urandom_range(1, 255));
				nodd = 1'($urandom_range(0, 1));
			end
			load_regs(nmax, nodd, phases_run == 0);
			phase_start = sent_items;
			while (sent_items - phase_start < PHASE_BYTES) begin
				quiet = ($urandom_range(0, 4) == 0);
				push_message();
				send_queued();
			end
			phases_run++;
		end

		wait_idle(16);
		$display("Sent %0d body bytes over %0d register settings; checked %0d result beats.",
			sent_items, phases_run + 2, results_seen);
		$display("Completed %0d messages; error kinds raised (bit per kind): %b.",
			done_seen, kinds_seen);
		if (fail_count == 0 && outstanding == 0) begin
			$display("tb_http_chunked_body_decoder: PASS");
		end else begin
			$display("tb_http_chunked_body_decoder: FAIL");
		end
		$finish;
	end

endmodule
